### hdl/gcon_pkg.sv
package gcon_pkg;

   // widest vertex id carried in cell commands (MAX_VERTICES up to 256)
   localparam int ID_W   = 8;
   localparam int TYPE_W = 3;
   localparam int VID_W  = 5;
   localparam int STAT_W = 2;
   localparam int ANS_W  = 5;
   localparam int VCNT_W = 6;
   localparam int EDGE_W = 13;

   localparam logic [TYPE_W-1:0] REQ_VADD = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_VREM = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_EADD = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_EREM = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_CONN = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_ART  = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_BRG  = 3'd6;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_REJECT   = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_ID    = 2'd2;
   localparam logic [STAT_W-1:0] ST_NO_EDGE  = 2'd3;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_INC  = 2'd1;
   localparam logic [1:0] OP_DEC  = 2'd2;
   localparam logic [1:0] OP_CLRV = 2'd3;

   typedef struct packed {
      logic [1:0]      op;
      logic [ID_W-1:0] a;
      logic [ID_W-1:0] b;
      logic            skip_en;  // vertex a left out of sweeps
      logic            excl_en;  // pair a-b left out of sweeps
   } gcon_cmd_type;

endpackage

### hdl/gcon_req_if.sv
interface gcon_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [4:0] vertex_a;
   logic [4:0] vertex_b;

   modport source (output valid, req_type, vertex_a, vertex_b, input ready);
   modport sink (input valid, req_type, vertex_a, vertex_b, output ready);
endinterface

### hdl/gcon_rsp_if.sv
interface gcon_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [4:0]  answer;
   logic [5:0]  vertex_count;
   logic [12:0] edge_count;

   modport source (output valid, status, answer, vertex_count, edge_count, input ready);
   modport sink (input valid, status, answer, vertex_count, edge_count, output ready);
endinterface

### hdl/gcon_ram.sv
module gcon_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### hdl/gcon_cell.sv
module gcon_cell #(
   parameter int MAX_VERTICES = 32,
   parameter int MULT_BITS    = 4,
   parameter int IDX          = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gcon_pkg::gcon_cmd_type      cmd,
   input  logic [MAX_VERTICES-1:0]     active,
   input  logic                        seen,
   input  logic [MAX_VERTICES-1:0]     acc_in,
   input  logic [gcon_pkg::EDGE_W-1:0] sum_in,
   output logic [MAX_VERTICES-1:0]     acc_out,
   output logic [gcon_pkg::EDGE_W-1:0] sum_out,
   output logic [MULT_BITS-1:0]        col_a
);
   import gcon_pkg::*;

   localparam int IW = $clog2(MAX_VERTICES);

   logic [MULT_BITS-1:0]    row_ff [MAX_VERTICES];
   logic [MULT_BITS-1:0]    row_in [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] acc_ff;
   logic [EDGE_W-1:0]       sum_ff;
   logic [MAX_VERTICES-1:0] usable;
   logic [IW-1:0]           a_ix;
   logic [IW-1:0]           b_ix;
   logic                    self_a;
   logic                    self_b;

   assign a_ix   = cmd.a[IW-1:0];
   assign b_ix   = cmd.b[IW-1:0];
   assign self_a = cmd.a == ID_W'(IDX);
   assign self_b = cmd.b == ID_W'(IDX);
   assign col_a  = row_ff[a_ix];

   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         usable[j] = (row_ff[j] != '0) && active[j]
                     && !(cmd.skip_en && cmd.a == ID_W'(j))
                     && !(cmd.excl_en && ((self_a && cmd.b == ID_W'(j))
                                          || (self_b && cmd.a == ID_W'(j))));
      end
   end

   always_comb begin
      row_in = row_ff;
      case (cmd.op)
         OP_INC: begin
            if (self_a) row_in[b_ix] = row_ff[b_ix] + 1'b1;
            if (self_b) row_in[a_ix] = row_ff[a_ix] + 1'b1;
         end
         OP_DEC: begin
            if (self_a) row_in[b_ix] = row_ff[b_ix] - 1'b1;
            if (self_b) row_in[a_ix] = row_ff[a_ix] - 1'b1;
         end
         OP_CLRV: begin
            if (self_a) begin
               for (int j = 0; j < MAX_VERTICES; j++) row_in[j] = '0;
            end
            row_in[a_ix] = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_VERTICES; j++) row_ff[j] <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   // reach and column-sum words move one cell down the row every cycle
   always_ff @(posedge clock) begin
      acc_ff <= acc_in | (seen ? usable : '0);
      sum_ff <= sum_in + EDGE_W'(col_a);
   end

   assign acc_out = acc_ff;
   assign sum_out = sum_ff;
endmodule

### hdl/dynamic_graph_connectivity_engine.sv
// Dynamic graph connectivity engine.
// req_ch takes one word per operation (vertex add/remove, edge add/remove,
// connected, articulation, bridge); rsp_ch returns exactly one word per
// request with status, answer, active vertex count and total edge count.
// Both channels use valid/ready; a word moves when both are high.
// One request is worked on at a time. Vertex add and edge operations go
// through decode and execute straight to the done state. Vertex remove
// also waits while a column sum walks down the cell row. Queries run
// reachability sweeps; in each sweep the reach word walks the row.
// Connected needs up to MAX_VERTICES sweeps; articulation and bridge count
// components twice, up to about 2 * (vertices + components) sweeps.
// A finished response sits in an output register, so the next request is
// taken while rsp_ch is stalled; a new result waits until that slot frees.
// Reset empties the graph: no active vertex, no edge, ids restart at 0.
module dynamic_graph_connectivity_engine #(
   parameter int MAX_VERTICES = 32,
   parameter int MULT_BITS    = 4
) (
   input logic clock,
   input logic reset,
   gcon_req_if.sink   req_ch,
   gcon_rsp_if.source rsp_ch
);
   import gcon_pkg::*;

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_SUM    = 3'd3;
   localparam logic [2:0] S_PICK   = 3'd4;
   localparam logic [2:0] S_SWEEP  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [TYPE_W-1:0]       op_ff, op_in;
   logic [VID_W-1:0]        a_ff, a_in, b_ff, b_in;
   logic [MAX_VERTICES-1:0] active_ff, active_in, seen_ff, seen_in;
   logic [CW-1:0]           vcount_ff, vcount_in, fresh_ff, fresh_in, fill_ff, fill_in;
   logic [CW-1:0]           cnt_ff, cnt_in, comps_ff, comps_in, comps0_ff, comps0_in;
   logic [IW-1:0]           head_ff, head_in, tail_ff, tail_in;
   logic [EDGE_W-1:0]       total_ff, total_in;
   logic                    pass_ff, pass_in;
   logic [STAT_W-1:0]       status_ff, status_in;
   logic [ANS_W-1:0]        answer_ff, answer_in;

   logic                    rsp_valid_ff;
   logic [STAT_W-1:0]       rsp_status_ff;
   logic [ANS_W-1:0]        rsp_answer_ff;
   logic [VCNT_W-1:0]       rsp_vcount_ff;
   logic [EDGE_W-1:0]       rsp_edges_ff;
   logic                    rsp_load;

   gcon_cmd_type            cmd;
   logic [MAX_VERTICES-1:0] acc_w [MAX_VERTICES];
   logic [EDGE_W-1:0]       sum_w [MAX_VERTICES];
   logic [MULT_BITS-1:0]    col_w [MAX_VERTICES];

   logic                    ram_we;
   logic [IW-1:0]           ram_rdata;

   logic [IW-1:0]           a_ix, b_ix;
   logic                    a_ok, b_ok, a_act, b_act;
   logic [MAX_VERTICES-1:0] a_oh, skip_mask, elig, pick_oh, grow;
   logic [MULT_BITS-1:0]    mult_ab;
   logic                    sweep_end;

   assign a_ix      = IW'(a_ff);
   assign b_ix      = IW'(b_ff);
   assign a_ok      = int'(a_ff) < MAX_VERTICES;
   assign b_ok      = int'(b_ff) < MAX_VERTICES;
   assign a_act     = a_ok && active_ff[a_ix];
   assign b_act     = b_ok && active_ff[b_ix];
   assign a_oh      = MAX_VERTICES'(1) << a_ix;
   assign mult_ab   = col_w[b_ix];
   assign skip_mask = (pass_ff && op_ff == REQ_ART) ? a_oh : '0;
   assign elig      = active_ff & ~seen_ff & ~skip_mask;
   assign pick_oh   = elig & (~elig + 1'b1);
   assign grow      = acc_w[MAX_VERTICES-1] & ~seen_ff;
   assign sweep_end = cnt_ff == CW'(MAX_VERTICES);
   assign rsp_load  = state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready);

   genvar gi;
   generate
      for (gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
         logic [MAX_VERTICES-1:0] acc_in_w;
         logic [EDGE_W-1:0]       sum_in_w;
         if (gi == 0) begin : g_first
            assign acc_in_w = '0;
            assign sum_in_w = '0;
         end else begin : g_next
            assign acc_in_w = acc_w[gi-1];
            assign sum_in_w = sum_w[gi-1];
         end
         gcon_cell #(
            .MAX_VERTICES(MAX_VERTICES),
            .MULT_BITS   (MULT_BITS),
            .IDX         (gi)
         ) u_cell (
            .clock  (clock),
            .reset  (reset),
            .cmd    (cmd),
            .active (active_ff),
            .seen   (seen_ff[gi]),
            .acc_in (acc_in_w),
            .sum_in (sum_in_w),
            .acc_out(acc_w[gi]),
            .sum_out(sum_w[gi]),
            .col_a  (col_w[gi])
         );
      end
   endgenerate

   gcon_ram #(
      .WIDTH(IW),
      .DEPTH(MAX_VERTICES)
   ) u_recycle (
      .clock(clock),
      .we   (ram_we),
      .waddr(tail_ff),
      .wdata(a_ix),
      .raddr(head_ff),
      .rdata(ram_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      active_in = active_ff;
      seen_in   = seen_ff;
      vcount_in = vcount_ff;
      fresh_in  = fresh_ff;
      fill_in   = fill_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      total_in  = total_ff;
      cnt_in    = cnt_ff + 1'b1;
      comps_in  = comps_ff;
      comps0_in = comps0_ff;
      pass_in   = pass_ff;
      status_in = status_ff;
      answer_in = answer_ff;
      ram_we    = 1'b0;
      cmd.op      = OP_NONE;
      cmd.a       = ID_W'(a_ff);
      cmd.b       = ID_W'(b_ff);
      cmd.skip_en = pass_ff && op_ff == REQ_ART;
      cmd.excl_en = pass_ff && op_ff == REQ_BRG;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.req_type;
               a_in     = req_ch.vertex_a;
               b_in     = req_ch.vertex_b;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            // recycle RAM read data for head_ff is valid from here on
            status_in = ST_REJECT;
            answer_in = '0;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            cnt_in   = '0;
            case (op_ff)
               REQ_VADD: begin
                  if (fill_ff != '0) begin
                     active_in[ram_rdata] = 1'b1;
                     vcount_in = vcount_ff + CW'(!active_ff[ram_rdata]);
                     head_in   = (head_ff == IW'(MAX_VERTICES - 1)) ? '0 : head_ff + 1'b1;
                     fill_in   = fill_ff - 1'b1;
                     answer_in = ANS_W'(ram_rdata);
                     status_in = ST_OK;
                  end else if (fresh_ff < CW'(MAX_VERTICES)) begin
                     active_in[IW'(fresh_ff)] = 1'b1;
                     vcount_in = vcount_ff + 1'b1;
                     fresh_in  = fresh_ff + 1'b1;
                     answer_in = ANS_W'(fresh_ff);
                     status_in = ST_OK;
                  end else begin
                     status_in = ST_NO_ID;
                  end
               end
               REQ_VREM: begin
                  if (a_act) state_in = S_SUM;
               end
               REQ_EADD: begin
                  if (a_act && b_act && a_ff != b_ff && mult_ab != '1) begin
                     cmd.op    = OP_INC;
                     total_in  = total_ff + 1'b1;
                     status_in = ST_OK;
                  end
               end
               REQ_EREM: begin
                  if (a_ok && b_ok) begin
                     if (mult_ab == '0) begin
                        status_in = ST_NO_EDGE;
                     end else begin
                        cmd.op    = OP_DEC;
                        total_in  = total_ff - 1'b1;
                        status_in = ST_OK;
                     end
                  end
               end
               REQ_CONN: begin
                  if (a_act && b_act) begin
                     seen_in  = a_oh;
                     pass_in  = 1'b0;
                     state_in = S_SWEEP;
                  end
               end
               REQ_ART, REQ_BRG: begin
                  if (a_act && (op_ff == REQ_ART || b_act)) begin
                     seen_in  = '0;
                     comps_in = '0;
                     pass_in  = 1'b0;
                     state_in = S_PICK;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SUM: begin
            if (sweep_end) begin
               cmd.op        = OP_CLRV;
               total_in      = total_ff - sum_w[MAX_VERTICES-1];
               active_in[a_ix] = 1'b0;
               vcount_in     = vcount_ff - 1'b1;
               if (fill_ff < CW'(MAX_VERTICES)) begin
                  ram_we  = 1'b1;
                  tail_in = (tail_ff == IW'(MAX_VERTICES - 1)) ? '0 : tail_ff + 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
               status_in = ST_OK;
               state_in  = S_DONE;
            end
         end
         S_PICK: begin
            cnt_in = '0;
            if (elig != '0) begin
               seen_in  = seen_ff | pick_oh;
               comps_in = comps_ff + 1'b1;
               state_in = S_SWEEP;
            end else if (!pass_ff) begin
               comps0_in = comps_ff;
               comps_in  = '0;
               seen_in   = '0;
               pass_in   = 1'b1;
            end else begin
               answer_in = ANS_W'(comps_ff > comps0_ff);
               status_in = ST_OK;
               pass_in   = 1'b0;
               state_in  = S_DONE;
            end
         end
         S_SWEEP: begin
            if (sweep_end) begin
               cnt_in = '0;
               if (grow != '0) begin
                  seen_in = seen_ff | grow;
               end else if (op_ff == REQ_CONN) begin
                  answer_in = ANS_W'(seen_ff[b_ix]);
                  status_in = ST_OK;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_PICK;
               end
            end
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         vcount_ff    <= '0;
         fresh_ff     <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         total_ff     <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         vcount_ff <= vcount_in;
         fresh_ff  <= fresh_in;
         fill_ff   <= fill_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         total_ff  <= total_in;
         pass_ff   <= pass_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      seen_ff   <= seen_in;
      cnt_ff    <= cnt_in;
      comps_ff  <= comps_in;
      comps0_ff <= comps0_in;
      status_ff <= status_in;
      answer_ff <= answer_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_answer_ff <= answer_ff;
         rsp_vcount_ff <= VCNT_W'(vcount_ff);
         rsp_edges_ff  <= total_ff;
      end
   end

   assign req_ch.ready        = state_ff == S_IDLE;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.answer       = rsp_answer_ff;
   assign rsp_ch.vertex_count = rsp_vcount_ff;
   assign rsp_ch.edge_count   = rsp_edges_ff;

   a_vcount_range: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= CW'(MAX_VERTICES))
      else $error("active vertex count beyond slot count");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_VERTICES) && fresh_ff <= CW'(MAX_VERTICES))
      else $error("recycle fill or fresh id out of range");

   a_sweep_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP || state_ff == S_SUM) |-> cnt_ff <= CW'(MAX_VERTICES))
      else $error("sweep counter overran the cell row");

   a_done_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished result not presented");
endmodule
